// ===== rtl/ilog2_pkg.sv =====
// Shared types and constants of the fixed-point base-2 logarithm block.
`timescale 1ns / 1ps
package ilog2_pkg;

	localparam int unsigned VALUE_W           = 32;
	localparam int unsigned RESULT_W          = 32;
	localparam int unsigned FRAC_CFG_W        = 5;
	localparam int unsigned SHIFT_CFG_W       = 4;
	localparam int unsigned CFG_DATA_W        = 5;
	localparam int unsigned CFG_ADDR_W        = 1;
	localparam int unsigned MAX_FRACTION_BITS = 16;
	localparam int unsigned MANT_W            = 16;
	localparam int unsigned MSB_W             = 5;
	localparam int unsigned QUEUE_DEPTH       = 4;
	localparam int unsigned QPTR_W            = 2;
	localparam int unsigned QCNT_W            = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_ADDR_W-1:0] CFG_FRACTION_BITS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_SHIFT  = 1'b1;

	localparam logic [FRAC_CFG_W-1:0]  FRACTION_BITS_RST = 5'd8;
	localparam logic [SHIFT_CFG_W-1:0] OUTPUT_SHIFT_RST  = 4'd0;
	localparam logic [SHIFT_CFG_W-1:0] FULL_SHIFT        = 4'd15;

	// A classified item: zero flag, integer part and 1.15 mantissa.
	typedef struct packed {
		logic              zero;
		logic [MSB_W-1:0]  msb;
		logic [MANT_W-1:0] mant;
	} norm_t;

	// Settings seen by the squaring pipeline; steps is already saturated.
	typedef struct packed {
		logic [FRAC_CFG_W-1:0]  steps;
		logic [SHIFT_CFG_W-1:0] shift;
	} cfg_t;

endpackage

// ===== rtl/ilog2_front.sv =====
// Front end: accepts values, finds the leading one and normalises the mantissa.
`timescale 1ns / 1ps
module ilog2_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic [ilog2_pkg::VALUE_W-1:0]         value,
	output logic                                  full,
	input  logic                                  q_full,
	output logic                                  q_push,
	output ilog2_pkg::norm_t                      q_item
);

	logic [ilog2_pkg::MSB_W-1:0]   msb_c;
	logic [ilog2_pkg::VALUE_W-1:0] shifted_c;
	ilog2_pkg::norm_t              item_c;
	logic                          vld_s1;
	ilog2_pkg::norm_t              item_s1;
	logic                          stall;

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < ilog2_pkg::VALUE_W; b++) begin
			if (value[b]) begin
				msb_c = ilog2_pkg::MSB_W'(b);
			end
		end
		if (msb_c >= 5'd15) begin
			shifted_c = value >> (msb_c - 5'd15);
		end else begin
			shifted_c = value << (5'd15 - msb_c);
		end
		item_c.zero = (value == '0);
		item_c.msb  = msb_c;
		item_c.mant = shifted_c[ilog2_pkg::MANT_W-1:0];
	end

	assign stall  = vld_s1 & q_full;
	assign full   = stall;
	assign q_push = vld_s1 & ~q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && push) begin
			item_s1 <= item_c;
		end
	end

	// A non-zero value always normalises to a mantissa with its leading one at the top.
	a_mant_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !item_s1.zero) |-> item_s1.mant[ilog2_pkg::MANT_W-1])
		else $error("front: mantissa not normalised");

endmodule

// ===== rtl/ilog2_queue.sv =====
// Short queue of classified items between the front end and the squaring pipeline.
`timescale 1ns / 1ps
module ilog2_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ilog2_pkg::norm_t wr_item,
	output logic             full,
	input  logic             rd_en,
	output logic             rd_valid,
	output ilog2_pkg::norm_t rd_item
);

	ilog2_pkg::norm_t                 mem_q [ilog2_pkg::QUEUE_DEPTH];
	logic [ilog2_pkg::QPTR_W-1:0]     wptr_q;
	logic [ilog2_pkg::QPTR_W-1:0]     rptr_q;
	logic [ilog2_pkg::QCNT_W-1:0]     cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full     = (cnt_q == ilog2_pkg::QCNT_W'(ilog2_pkg::QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ilog2_pkg::QCNT_W'(ilog2_pkg::QUEUE_DEPTH))
		else $error("queue: fill count beyond depth");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("queue: write while full");

endmodule

// ===== rtl/ilog2_back.sv =====
// Back end: squaring pipeline, result assembly and a two-entry output buffer.
`timescale 1ns / 1ps
module ilog2_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ilog2_pkg::cfg_t                   cfg,
	input  logic                              q_valid,
	input  ilog2_pkg::norm_t                  q_item,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [ilog2_pkg::RESULT_W-1:0]    log_result
);

	localparam int unsigned NSTAGE = ilog2_pkg::MAX_FRACTION_BITS;
	localparam int unsigned FRAC_W = ilog2_pkg::MAX_FRACTION_BITS;

	logic                          vld_s   [1:NSTAGE];
	ilog2_pkg::norm_t              item_s  [1:NSTAGE];
	logic [FRAC_W-1:0]             frac_s  [1:NSTAGE];
	logic                          nxt_vld [1:NSTAGE];
	ilog2_pkg::norm_t              nxt_item[1:NSTAGE];
	logic [FRAC_W-1:0]             nxt_frac[1:NSTAGE];

	logic                          adv;
	logic [ilog2_pkg::RESULT_W-1:0] res_c;

	logic [ilog2_pkg::RESULT_W-1:0] obuf_q [2];
	logic                          owptr_q;
	logic                          orptr_q;
	logic [1:0]                    ocnt_q;
	logic                          ofull;
	logic                          owr;
	logic                          ord;

	// The whole pipeline holds only when its last stage cannot drain.
	assign adv   = ~(vld_s[NSTAGE] & ofull);
	assign q_pop = q_valid & adv;

	// One squaring per stage; stages beyond the configured count pass through.
	always_comb begin
		ilog2_pkg::norm_t  in_item;
		logic [FRAC_W-1:0] in_frac;
		logic              in_vld;
		logic [31:0]       sq;
		for (int k = 1; k <= NSTAGE; k++) begin
			if (k == 1) begin
				in_vld  = q_valid;
				in_item = q_item;
				in_frac = '0;
			end else begin
				in_vld  = vld_s[k-1];
				in_item = item_s[k-1];
				in_frac = frac_s[k-1];
			end
			sq          = 32'(in_item.mant) * 32'(in_item.mant);
			nxt_vld[k]  = in_vld;
			nxt_item[k] = in_item;
			nxt_frac[k] = in_frac;
			if (k <= int'(cfg.steps)) begin
				nxt_item[k].mant = sq[31] ? sq[31:16] : sq[30:15];
				nxt_frac[k]      = {in_frac[FRAC_W-2:0], sq[31]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				vld_s[k] <= nxt_vld[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				item_s[k] <= nxt_item[k];
				frac_s[k] <= nxt_frac[k];
			end
		end
	end

	// Result assembly from the last stage.
	always_comb begin
		logic [ilog2_pkg::RESULT_W-1:0] base;
		logic [ilog2_pkg::RESULT_W-1:0] fill;
		base = (ilog2_pkg::RESULT_W'(item_s[NSTAGE].msb) << cfg.steps)
			+ ilog2_pkg::RESULT_W'(frac_s[NSTAGE]);
		fill = ilog2_pkg::RESULT_W'(item_s[NSTAGE].mant[ilog2_pkg::MANT_W-2:0])
			>> (ilog2_pkg::FULL_SHIFT - cfg.shift);
		res_c = base << cfg.shift;
		if (cfg.shift != ilog2_pkg::FULL_SHIFT) begin
			res_c = res_c | fill;
		end
		if (item_s[NSTAGE].zero) begin
			res_c = '0;
		end
	end

	// Two-entry output buffer.
	assign ofull      = (ocnt_q == 2'd2);
	assign empty      = (ocnt_q == 2'd0);
	assign owr        = adv & vld_s[NSTAGE];
	assign ord        = pop & ~empty;
	assign log_result = obuf_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (owr) begin
				owptr_q <= ~owptr_q;
			end
			if (ord) begin
				orptr_q <= ~orptr_q;
			end
			if (owr && !ord) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (!owr && ord) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (owr) begin
			obuf_q[owptr_q] <= res_c;
		end
	end

	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("back: output buffer count out of range");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		owr |-> !ofull)
		else $error("back: write into full output buffer");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NSTAGE] && ofull && !ord) |=> vld_s[NSTAGE])
		else $error("back: last stage lost while stalled");

endmodule

// ===== rtl/integer_log2_fixed_point.sv =====
// Top level of the fixed-point base-2 logarithm block.
`timescale 1ns / 1ps
// Usage
// Both channels behave as queues. A value beat is taken at a rising edge with
// push high and full low; a result beat leaves at a rising edge with pop high
// and empty low, and the oldest result is on log_result whenever empty is low.
// Each value gives exactly one result, in order. A zero value gives zero.
// The front end registers the value together with its leading-one index and
// normalised 1.15 mantissa, and hands it to a four-entry queue. The back end
// is a sixteen-stage pipeline, one squaring multiplier per stage, followed by
// result assembly into a two-entry output buffer.
// From the accepting edge, a result passes the front register, the queue and
// the sixteen squaring stages before empty goes low. Throughput is one
// beat per clock, sustained as long as pop keeps up.
// When the receiver stalls, the output buffer fills, the pipeline holds, the
// queue fills and full rises; nothing is dropped.
// Reset clears every valid flag and buffer count and loads fraction_bits with
// eight and output_shift with zero. Configuration writes take effect at once
// and are only to be issued while the block is empty of work.
module integer_log2_fixed_point (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic [ilog2_pkg::VALUE_W-1:0]        value,
	output logic                                 full,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [ilog2_pkg::RESULT_W-1:0]       log_result,
	input  logic                                 cfg_we,
	input  logic [ilog2_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [ilog2_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [ilog2_pkg::FRAC_CFG_W-1:0]  fraction_bits_q;
	logic [ilog2_pkg::SHIFT_CFG_W-1:0] output_shift_q;
	ilog2_pkg::cfg_t                   cfg;

	logic             q_push;
	ilog2_pkg::norm_t q_wr_item;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	ilog2_pkg::norm_t q_rd_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_bits_q <= ilog2_pkg::FRACTION_BITS_RST;
			output_shift_q  <= ilog2_pkg::OUTPUT_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ilog2_pkg::CFG_FRACTION_BITS: begin
					fraction_bits_q <= cfg_wdata;
				end
				ilog2_pkg::CFG_OUTPUT_SHIFT: begin
					output_shift_q <= cfg_wdata[ilog2_pkg::SHIFT_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// More fraction bits than the pipeline has stages saturate to its length.
	always_comb begin
		if (fraction_bits_q > ilog2_pkg::FRAC_CFG_W'(ilog2_pkg::MAX_FRACTION_BITS)) begin
			cfg.steps = ilog2_pkg::FRAC_CFG_W'(ilog2_pkg::MAX_FRACTION_BITS);
		end else begin
			cfg.steps = fraction_bits_q;
		end
		cfg.shift = output_shift_q;
	end

	ilog2_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.value  (value),
		.full   (full),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_wr_item)
	);

	ilog2_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	ilog2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_item     (q_rd_item),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.log_result (log_result)
	);

endmodule
